// ----- design/dsrt_pkg.sv -----
package dsrt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam int LinkCount = 32;

  localparam logic [3:0] OP_QUERY  = 4'd0;
  localparam logic [3:0] OP_SEND   = 4'd1;
  localparam logic [3:0] OP_ACK    = 4'd2;
  localparam logic [3:0] OP_RX     = 4'd3;
  localparam logic [3:0] OP_HOPS   = 4'd4;
  localparam logic [3:0] OP_TIME   = 4'd5;
  localparam logic [3:0] OP_SETMTU = 4'd6;
  localparam logic [3:0] OP_RAISE  = 4'd7;
  localparam logic [3:0] OP_TEST   = 4'd8;
  localparam logic [3:0] OP_RESENT = 4'd9;
  localparam logic [3:0] OP_COUNT  = 4'd10;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] ack;
    logic [15:0] send;
    logic [15:0] rx;
    logic [7:0]  hops;
    logic [31:0] tm;
    logic [4:0]  blink;
    logic [15:0] mtu;
    logic [15:0] test;
    logic [15:0] resent;
  } entry_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] address;
    logic [31:0] value;
    logic [4:0]  link;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  entry_index;
    logic [15:0] ack_expected;
    logic [15:0] send_sequence;
    logic [15:0] receive_expected;
    logic [7:0]  min_hops;
    logic [31:0] link_mask;
    logic [15:0] min_mtu;
    logic [15:0] test_count;
    logic [15:0] resent_flag;
    logic        updated;
    logic [4:0]  unset_count;
  } resp_t;

  // Scan result token, built up from the head cell as the ring of cells rotates.
  typedef struct packed {
    logic        found;
    logic [CntW-1:0] pos;
    logic [CntW-1:0] zeros;
  } token_t;

  function automatic entry_t apply_op(entry_t e, req_t r, output logic upd);
    entry_t o;
    logic [15:0] sat16;
    logic [7:0] h;
    o = e;
    upd = 1'b0;
    sat16 = (r.value > 32'hFFFF) ? 16'hFFFF : r.value[15:0];
    h = (r.value > 32'd255) ? 8'hFF : r.value[7:0];
    case (r.operation)
      OP_SEND: o.send = e.send + 16'd1;
      OP_ACK: o.ack = e.ack + 16'd1;
      OP_RX: o.rx = e.rx + 16'd1;
      OP_HOPS: begin
        if (e.hops > h) begin
          o.hops = h;
          o.blink = r.link;
        end
      end
      OP_TIME: begin
        if (e.tm > r.value) begin
          o.tm = r.value;
          o.blink = r.link;
        end
      end
      OP_SETMTU: o.mtu = sat16;
      OP_RAISE: begin
        if (e.blink == r.link && e.mtu < sat16) begin
          o.mtu = sat16;
          upd = 1'b1;
        end
      end
      OP_TEST: begin
        if (e.test != 16'hFFFF) o.test = e.test + 16'd1;
      end
      OP_RESENT: o.resent = r.value[15:0];
      default: o = e;
    endcase
    return o;
  endfunction

endpackage

// ----- design/dsrt_if.sv -----
interface dsrt_req_if;
  logic valid;
  logic ready;
  dsrt_pkg::req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface dsrt_resp_if;
  logic valid;
  logic ready;
  dsrt_pkg::resp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- design/dsrt_cell.sv -----
module dsrt_cell (
  input  logic              clk,
  input  logic              rot,
  input  logic              load,
  input  dsrt_pkg::entry_t  load_entry,
  input  dsrt_pkg::entry_t  prev_entry,
  output dsrt_pkg::entry_t  entry
);
  // One table slot; the row rotates as a ring during a scan.
  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_entry;
    end else if (rot) begin
      entry <= prev_entry;
    end
  end
endmodule

// ----- design/destination_sequence_route_table_unit.sv -----
// Destination sequence and route table.
// Requests arrive on req (operation, address, value, link) and one result per
// request leaves on resp. The table is a ring of 16 cells. For each request the
// ring rotates one slot per cycle through all 16 slots; the head cell is compared
// with the address and its MTU checked. The scan is followed by an update
// state, in which the result register is loaded and result valid is raised.
// One request is handled at a time: a new request is taken only once the
// previous result has been taken. After the scan every cell is back in place.
// A hit or a free slot is updated in the update state; when the table is full
// and the address is absent, status 1 is returned with no change. The count
// operation reports the number of used entries with MTU zero.
// Reset clears the entry count and the control; stored entries are undefined
// until created. The result is held in an output register until the receiver
// takes it; while it waits no new request is accepted.
module destination_sequence_route_table_unit (
  input logic clk,
  input logic rst,
  dsrt_req_if.sink    req,
  dsrt_resp_if.source resp
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [dsrt_pkg::CntW-1:0] entry_count;
  logic [dsrt_pkg::CntW-1:0] step;
  dsrt_pkg::req_t cur;
  dsrt_pkg::token_t tok;
  dsrt_pkg::resp_t res;
  dsrt_pkg::resp_t res_next;
  logic resp_valid;

  dsrt_pkg::entry_t ent [dsrt_pkg::TableDepth];
  dsrt_pkg::entry_t new_entry;
  dsrt_pkg::entry_t base;
  logic [dsrt_pkg::IdxW-1:0] target;
  logic upd;
  logic full_miss;
  logic [4:0] bl;

  // ent[0] is the head; the slot index in ent[0] during the scan is step.
  always_comb begin
    target = tok.found ? tok.pos[dsrt_pkg::IdxW-1:0] : entry_count[dsrt_pkg::IdxW-1:0];
    full_miss = !tok.found && (entry_count == 5'(dsrt_pkg::TableDepth));
    if (tok.found) begin
      base = ent[target];
    end else begin
      base = '0;
      base.key = cur.address;
      base.hops = 8'hFF;
      base.tm = 32'hFFFFFFFF;
    end
    new_entry = dsrt_pkg::apply_op(base, cur, upd);
    res_next = '0;
    if (cur.operation == dsrt_pkg::OP_COUNT) begin
      res_next.unset_count = tok.zeros;
    end else if (full_miss) begin
      res_next.status = 1'b1;
    end else begin
      res_next.entry_index = target;
      res_next.ack_expected = new_entry.ack;
      res_next.send_sequence = base.send;
      res_next.receive_expected = new_entry.rx;
      res_next.min_hops = new_entry.hops;
      res_next.link_mask = (bl == 5'd0) ? 32'hFFFFFFFF : (32'd1 << bl);
      res_next.min_mtu = new_entry.mtu;
      res_next.test_count = new_entry.test;
      res_next.resent_flag = new_entry.resent;
      res_next.updated = upd;
    end
  end

  for (genvar g = 0; g < dsrt_pkg::TableDepth; g++) begin : g_cell
    dsrt_cell u_cell (
      .clk(clk),
      .rot(state == S_SCAN),
      .load(state == S_UPD && !full_miss && cur.operation != dsrt_pkg::OP_COUNT &&
            target == dsrt_pkg::IdxW'(g)),
      .load_entry(new_entry),
      .prev_entry(ent[(g + 1) % dsrt_pkg::TableDepth]),
      .entry(ent[g])
    );
  end

  assign req.ready = (state == S_IDLE);
  assign resp.valid = resp_valid;
  assign resp.payload = res;
  assign bl = new_entry.blink;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      resp_valid <= 1'b0;
      step <= '0;
      tok <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.payload;
            step <= '0;
            tok <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step < entry_count) begin
            if (!tok.found && ent[0].key == cur.address) begin
              tok.found <= 1'b1;
              tok.pos <= step;
            end
            if (ent[0].mtu == 16'd0) tok.zeros <= tok.zeros + 5'd1;
          end
          step <= step + 5'd1;
          if (step == 5'(dsrt_pkg::TableDepth - 1)) state <= S_UPD;
        end
        S_UPD: begin
          res <= res_next;
          if (cur.operation != dsrt_pkg::OP_COUNT && !full_miss && !tok.found) begin
            entry_count <= entry_count + 5'd1;
          end
          resp_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (resp.ready) begin
            resp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= 5'(dsrt_pkg::TableDepth)) else $error("entry count overflow");
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> state == S_OUT) else $error("result valid outside output state");
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    entry_count != $past(entry_count) |-> $past(state) == S_UPD)
    else $error("entry count changed outside update");
`endif
endmodule

// ----- dv/dsrt_checker.sv -----
`timescale 1ns / 1ps

module dsrt_checker (
  input  logic clk,
  input  logic rst,
  dsrt_req_if  req,
  dsrt_resp_if resp,
  output int   fail_count,
  output int   pending
);

  logic [4:0]  used_entries;
  logic [31:0] keys [dsrt_pkg::TableDepth];
  logic [15:0] ack_seq [dsrt_pkg::TableDepth];
  logic [15:0] send_seq [dsrt_pkg::TableDepth];
  logic [15:0] rx_seq [dsrt_pkg::TableDepth];
  logic [7:0]  best_hops [dsrt_pkg::TableDepth];
  logic [31:0] best_time [dsrt_pkg::TableDepth];
  logic [4:0]  best_link [dsrt_pkg::TableDepth];
  logic [15:0] path_mtu [dsrt_pkg::TableDepth];
  logic [15:0] test_seen [dsrt_pkg::TableDepth];
  logic [15:0] resent_word [dsrt_pkg::TableDepth];
  dsrt_pkg::resp_t route_results [$];

  assign pending = route_results.size();

  function automatic dsrt_pkg::resp_t route_lookup(dsrt_pkg::req_t r);
    dsrt_pkg::resp_t o;
    int slot;
    logic [15:0] sat16;
    logic [7:0] h;
    logic [4:0] bl;
    o = '0;
    slot = -1;
    sat16 = (r.value > 32'hFFFF) ? 16'hFFFF : r.value[15:0];
    h = (r.value > 32'd255) ? 8'hFF : r.value[7:0];
    if (r.operation == dsrt_pkg::OP_COUNT) begin
      for (int i = 0; i < used_entries; i++)
        if (path_mtu[i] == 16'd0) o.unset_count++;
      return o;
    end
    for (int i = 0; i < used_entries; i++)
      if (slot < 0 && keys[i] == r.address) slot = i;
    if (slot < 0) begin
      if (used_entries == dsrt_pkg::TableDepth) begin
        o.status = 1'b1;
        return o;
      end
      slot = used_entries;
      keys[slot] = r.address;
      ack_seq[slot] = '0;
      send_seq[slot] = '0;
      rx_seq[slot] = '0;
      best_hops[slot] = 8'hFF;
      best_time[slot] = '1;
      best_link[slot] = '0;
      path_mtu[slot] = '0;
      test_seen[slot] = '0;
      resent_word[slot] = '0;
      used_entries++;
    end
    o.send_sequence = send_seq[slot];
    case (r.operation)
      dsrt_pkg::OP_SEND: send_seq[slot]++;
      dsrt_pkg::OP_ACK: ack_seq[slot]++;
      dsrt_pkg::OP_RX: rx_seq[slot]++;
      dsrt_pkg::OP_HOPS: if (best_hops[slot] > h) begin
        best_hops[slot] = h;
        best_link[slot] = r.link;
      end
      dsrt_pkg::OP_TIME: if (best_time[slot] > r.value) begin
        best_time[slot] = r.value;
        best_link[slot] = r.link;
      end
      dsrt_pkg::OP_SETMTU: path_mtu[slot] = sat16;
      dsrt_pkg::OP_RAISE: if (best_link[slot] == r.link && path_mtu[slot] < sat16) begin
        path_mtu[slot] = sat16;
        o.updated = 1'b1;
      end
      dsrt_pkg::OP_TEST: if (test_seen[slot] != 16'hFFFF) test_seen[slot]++;
      dsrt_pkg::OP_RESENT: resent_word[slot] = r.value[15:0];
      default: ;
    endcase
    bl = best_link[slot];
    o.entry_index = slot[3:0];
    o.ack_expected = ack_seq[slot];
    o.receive_expected = rx_seq[slot];
    o.min_hops = best_hops[slot];
    o.link_mask = (bl == 0) ? 32'hFFFF_FFFF : 32'd1 << bl;
    o.min_mtu = path_mtu[slot];
    o.test_count = test_seen[slot];
    o.resent_flag = resent_word[slot];
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin
    dsrt_pkg::resp_t got;
    dsrt_pkg::resp_t want;
    if (rst) begin
      used_entries = '0;
      fail_count = 0;
    end else begin
      if (req.valid && req.ready) route_results.push_back(route_lookup(req.payload));
      if (resp.valid && resp.ready) begin
        got = resp.payload;
        if (route_results.size() == 0) begin
          report_mismatch("unexpected transfer", 32'd1, 32'd0);
        end else begin
          want = route_results.pop_front();
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("entry_index", 32'(got.entry_index), 32'(want.entry_index));
          check_field("ack_expected", 32'(got.ack_expected), 32'(want.ack_expected));
          check_field("send_sequence", 32'(got.send_sequence), 32'(want.send_sequence));
          check_field("receive_expected", 32'(got.receive_expected),
                      32'(want.receive_expected));
          check_field("min_hops", 32'(got.min_hops), 32'(want.min_hops));
          check_field("link_mask", got.link_mask, want.link_mask);
          check_field("min_mtu", 32'(got.min_mtu), 32'(want.min_mtu));
          check_field("test_count", 32'(got.test_count), 32'(want.test_count));
          check_field("resent_flag", 32'(got.resent_flag), 32'(want.resent_flag));
          check_field("updated", 32'(got.updated), 32'(want.updated));
          check_field("unset_count", 32'(got.unset_count), 32'(want.unset_count));
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int StallLimit = 2000;
  localparam int LongHold = 200;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sender_idle;
  int   receiver_stall;
  int   hold_cycles;
  logic hold_req;
  logic hold_taken;
  int   quiet_cycles;
  logic [31:0] key_pool [dsrt_pkg::TableDepth];

  dsrt_req_if  req ();
  dsrt_resp_if resp ();

  destination_sequence_route_table_unit i_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  dsrt_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .resp       (resp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_taken <= 1'b0;
      resp.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= LongHold;
      resp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      resp.ready <= 1'b0;
    end else begin
      resp.ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (resp.valid && resp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic [3:0] op, logic [31:0] addr, logic [31:0] val,
                              logic [4:0] lnk);
    dsrt_pkg::req_t r;
    if ($urandom_range(99) < sender_idle) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    r.operation = op;
    r.address = addr;
    r.value = val;
    r.link = lnk;
    req.valid <= 1'b1;
    req.payload <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [3:0] op;
    logic [31:0] addr;
    logic [31:0] val;
    logic [4:0] lnk;
    op = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 11))
                                   : 4'($urandom_range(dsrt_pkg::OP_COUNT,
                                                       dsrt_pkg::OP_QUERY));
    addr = ($urandom_range(99) < 10) ? $urandom()
                                     : key_pool[$urandom_range(dsrt_pkg::TableDepth - 1)];
    case ($urandom_range(3))
      0: val = $urandom_range(300);
      1: val = $urandom_range(70000, 65500);
      2: val = $urandom();
      default: val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
    lnk = ($urandom_range(1) != 0) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    send_request(op, addr, val, lnk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.payload = '0;
    sender_idle = 0;
    receiver_stall = 0;
    hold_req = 1'b0;
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < dsrt_pkg::TableDepth; i++) key_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(dsrt_pkg::OP_COUNT, 32'd0, 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_QUERY, key_pool[0], 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_SEND, key_pool[0], 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_SEND, key_pool[0], 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_ACK, key_pool[0], 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_RX, key_pool[0], 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_HOPS, key_pool[0], 32'd1000, 5'd31);
    send_request(dsrt_pkg::OP_HOPS, key_pool[0], 32'd3, 5'd5);
    send_request(dsrt_pkg::OP_TIME, key_pool[0], 32'hFFFF_FFFE, 5'd0);
    send_request(dsrt_pkg::OP_TIME, key_pool[0], 32'd0, 5'd31);
    send_request(dsrt_pkg::OP_SETMTU, key_pool[0], 32'hFFFF_FFFF, 5'd0);
    send_request(dsrt_pkg::OP_SETMTU, key_pool[0], 32'd100, 5'd0);
    send_request(dsrt_pkg::OP_RAISE, key_pool[0], 32'd200, 5'd3);
    send_request(dsrt_pkg::OP_RAISE, key_pool[0], 32'd200, 5'd31);
    send_request(dsrt_pkg::OP_RAISE, key_pool[0], 32'd50, 5'd31);
    send_request(dsrt_pkg::OP_TEST, key_pool[0], 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_RESENT, key_pool[0], 32'hABCD_1234, 5'd0);
    send_request(dsrt_pkg::OP_QUERY, key_pool[1], 32'hFFFF_FFFF, 5'd31);
    send_request(4'd15, key_pool[1], 32'd0, 5'd0);
    send_request(dsrt_pkg::OP_COUNT, 32'd0, 32'd0, 5'd0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 66 : 38) : 0;
      receiver_stall = (phase == 2) ? 66 : ((phase == 3) ? 38 : 0);
      for (int n = 0; n < 132; n++) begin
        if (n == 40 && phase == 2) hold_req = 1'b1;
        if (n == 80) drain();
        send_random();
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dsrt_pkg.sv
design/dsrt_if.sv
design/dsrt_cell.sv
design/destination_sequence_route_table_unit.sv
dv/dsrt_checker.sv
dv/tb_top.sv
